@@ design/gimli_pkg.sv @@
// Shared types and constants for the reduced-round Gimli permutation pipeline.
`timescale 1ns / 1ps

package gimli_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned NUM_WORDS  = 12;
    localparam int unsigned NUM_COLS   = 4;
    localparam int unsigned MAX_ROUNDS = 24;
    localparam int unsigned ROUNDS_DEF = 7;

    localparam logic [WORD_W-1:0] RC_BASE = 32'h9e37_7900;

    // SP-box rotation amounts
    localparam int unsigned ROT_X = 24;
    localparam int unsigned ROT_Y = 9;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [NUM_WORDS-1:0] state_t;

    // One column as seen by an SP-box lane: row 0, row 1, row 2
    typedef struct packed {
        word_t r0;
        word_t r1;
        word_t r2;
    } column_t;

endpackage

@@ design/gimli_spbox.sv @@
// Gimli SP-box applied to one column of the state.
`timescale 1ns / 1ps

module gimli_spbox
    import gimli_pkg::*;
(
    input  column_t col_in,
    output column_t col_out
);

    word_t x;
    word_t y;
    word_t z;

    assign x = {col_in.r0[WORD_W-ROT_X-1:0], col_in.r0[WORD_W-1:WORD_W-ROT_X]};
    assign y = {col_in.r1[WORD_W-ROT_Y-1:0], col_in.r1[WORD_W-1:WORD_W-ROT_Y]};
    assign z = col_in.r2;

    assign col_out.r2 = x ^ (z << 1) ^ ((y & z) << 2);
    assign col_out.r1 = y ^ x ^ ((x | z) << 1);
    assign col_out.r0 = z ^ y ^ ((x & y) << 3);

endmodule

@@ design/gimli_round.sv @@
// One pipelined Gimli round: four column lanes, then the swap / constant merge.
`timescale 1ns / 1ps

module gimli_round
    import gimli_pkg::*;
#(
    parameter int unsigned RND = MAX_ROUNDS
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   up_valid,
    output logic   up_ready,
    input  state_t up_state,
    output logic   dn_valid,
    input  logic   dn_ready,
    output state_t dn_state
);

    localparam logic [WORD_W-1:0] RC = RC_BASE | WORD_W'(RND);

    logic   valid_reg;
    logic   valid_next;
    state_t state_reg;
    state_t state_next;
    state_t mixed;
    state_t merged;

    // column lanes
    for (genvar c = 0; c < NUM_COLS; c++) begin : g_lane
        column_t lane_in;
        column_t lane_out;

        assign lane_in.r0 = up_state[c];
        assign lane_in.r1 = up_state[NUM_COLS + c];
        assign lane_in.r2 = up_state[2*NUM_COLS + c];

        gimli_spbox u_spbox (
            .col_in  (lane_in),
            .col_out (lane_out)
        );

        assign mixed[c]              = lane_out.r0;
        assign mixed[NUM_COLS + c]   = lane_out.r1;
        assign mixed[2*NUM_COLS + c] = lane_out.r2;
    end

    // merge: row-0 swaps and round constant, fixed per stage
    always_comb begin
        merged = mixed;
        if ((RND % 4) == 0) begin
            merged[0] = mixed[1] ^ RC;
            merged[1] = mixed[0];
            merged[2] = mixed[3];
            merged[3] = mixed[2];
        end else if ((RND % 4) == 2) begin
            merged[0] = mixed[2];
            merged[1] = mixed[3];
            merged[2] = mixed[0];
            merged[3] = mixed[1];
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_comb begin
        valid_next = valid_reg;
        state_next = state_reg;
        if (up_ready) begin
            valid_next = up_valid;
            if (up_valid) begin
                state_next = merged;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        state_reg <= state_next;
    end

    assign dn_valid = valid_reg;
    assign dn_state = state_reg;

endmodule

@@ design/gimli_reduced_round_permutation.sv @@
// Top level: reduced-round Gimli permutation, one pipeline stage per round.
// Each request passes through one register stage per round before its result is valid at the output.
// Throughput: one request per cycle while m_ready holds; each round has its own register stage.
// Stages hold independently, so empty stages keep filling while a result waits.
// Zero rounds: no stages, the request passes straight through in the same cycle.
// Reset (aresetn low, synchronous) clears every stage valid bit; data regs keep.
`timescale 1ns / 1ps

module gimli_reduced_round_permutation
    import gimli_pkg::*;
#(
    parameter int unsigned ROUNDS = ROUNDS_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,

    input  logic  s_valid,
    output logic  s_ready,
    input  word_t s_w0,
    input  word_t s_w1,
    input  word_t s_w2,
    input  word_t s_w3,
    input  word_t s_w4,
    input  word_t s_w5,
    input  word_t s_w6,
    input  word_t s_w7,
    input  word_t s_w8,
    input  word_t s_w9,
    input  word_t s_w10,
    input  word_t s_w11,

    output logic  m_valid,
    input  logic  m_ready,
    output word_t m_w0,
    output word_t m_w1,
    output word_t m_w2,
    output word_t m_w3,
    output word_t m_w4,
    output word_t m_w5,
    output word_t m_w6,
    output word_t m_w7,
    output word_t m_w8,
    output word_t m_w9,
    output word_t m_w10,
    output word_t m_w11
);

    // Rounds beyond 24 would run past round number 1; clamp to the full permutation.
    // Zero rounds leaves no stage at all: boundary 0 is then the output.
    localparam int unsigned NUM_STAGES = (ROUNDS > MAX_ROUNDS) ? MAX_ROUNDS : ROUNDS;

    // Boundary k sits in front of stage k; boundary NUM_STAGES is the output.
    logic   [NUM_STAGES:0] vld;
    logic   [NUM_STAGES:0] rdy;
    state_t                st [NUM_STAGES+1];

    assign vld[0] = s_valid;
    assign s_ready = rdy[0];
    assign st[0] = {s_w11, s_w10, s_w9, s_w8, s_w7, s_w6,
                    s_w5, s_w4, s_w3, s_w2, s_w1, s_w0};

    // Round numbers count down from 24, one stage each.
    for (genvar i = 0; i < NUM_STAGES; i++) begin : g_round
        gimli_round #(
            .RND (MAX_ROUNDS - i)
        ) u_round (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .up_valid (vld[i]),
            .up_ready (rdy[i]),
            .up_state (st[i]),
            .dn_valid (vld[i+1]),
            .dn_ready (rdy[i+1]),
            .dn_state (st[i+1])
        );
    end

    // With at least one round, the last stage register is the output register.
    assign rdy[NUM_STAGES] = m_ready;
    assign m_valid = vld[NUM_STAGES];
    assign m_w0  = st[NUM_STAGES][0];
    assign m_w1  = st[NUM_STAGES][1];
    assign m_w2  = st[NUM_STAGES][2];
    assign m_w3  = st[NUM_STAGES][3];
    assign m_w4  = st[NUM_STAGES][4];
    assign m_w5  = st[NUM_STAGES][5];
    assign m_w6  = st[NUM_STAGES][6];
    assign m_w7  = st[NUM_STAGES][7];
    assign m_w8  = st[NUM_STAGES][8];
    assign m_w9  = st[NUM_STAGES][9];
    assign m_w10 = st[NUM_STAGES][10];
    assign m_w11 = st[NUM_STAGES][11];

`ifndef NO_ASSERTIONS
    // A draining output never stalls the input.
    a_ready_when_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output is taken");

    // Stage checks only exist when there is at least one round stage.
    if (NUM_STAGES > 0) begin : g_stage_chk
        // Empty output stage means the whole ready chain is open.
        a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
            !m_valid |-> s_ready)
            else $error("input stalled while output stage is empty");

        // An accepted request lands in the first stage.
        a_first_stage_load: assert property (@(posedge aclk) disable iff (!aresetn)
            (s_valid && s_ready) |=> vld[1])
            else $error("accepted request lost at first stage");

        // A blocked first stage keeps its item.
        a_first_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
            (vld[1] && !rdy[1]) |=> (vld[1] && $stable(st[1])))
            else $error("first stage dropped or changed a held item");
    end
`endif

endmodule
